// File: hw/rtl/kvmsa_pkg.sv
// Package for the KV miss slot allocator: beat codes, bus widths, the
// sequencer's control word type and its read-only microprogram.
// Depends on nothing; imported by kv_miss_slot_allocator.
`default_nettype none

package kvmsa_pkg;

    // Default sizes handed to the top level's parameters.
    localparam int MAX_SLOTS_DEF  = 2048;
    localparam int TILE_COUNT_DEF = 32;

    // Field widths fixed by the bus format.
    localparam int REQ_W    = 2;
    localparam int ROW_W    = 31;
    localparam int CNT_W    = 12;
    localparam int SEL_W    = 32;
    localparam int SUM_W    = 17;
    localparam int SLOT_W   = 11;
    localparam int DST_W    = 42;
    localparam int CFG_W    = 12;
    localparam int S_DATA_W = 88;
    localparam int M_DATA_W = 128;
    localparam int M_PAD_W  = M_DATA_W - (4 * SUM_W + 1 + SLOT_W + DST_W);

    localparam logic [SUM_W-1:0] SUM_MAX = '1;
    localparam logic [CFG_W-1:0] ACTIVE_SLOTS_RST = 12'd2048;

    // Request kinds carried in s_tuser.
    localparam logic [REQ_W-1:0] REQ_BEGIN = 2'd0;
    localparam logic [REQ_W-1:0] REQ_TILE  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_HIT   = 2'd2;
    localparam logic [REQ_W-1:0] REQ_MISS  = 2'd3;

    // Result kinds carried in m_tuser.
    localparam logic RESP_TILE = 1'b0;
    localparam logic RESP_MISS = 1'b1;

    // Register index decoded from paddr[2].
    localparam logic REG_ACTIVE_SLOTS = 1'b0;

    // Microprogram steps.
    localparam int UPC_W = 3;
    localparam logic [UPC_W-1:0] ST_IDLE      = 3'd0;
    localparam logic [UPC_W-1:0] ST_BEGIN     = 3'd1;
    localparam logic [UPC_W-1:0] ST_TILE      = 3'd2;
    localparam logic [UPC_W-1:0] ST_HIT_RD    = 3'd3;
    localparam logic [UPC_W-1:0] ST_HIT_WR    = 3'd4;
    localparam logic [UPC_W-1:0] ST_MISS_RD   = 3'd5;
    localparam logic [UPC_W-1:0] ST_MISS_EVAL = 3'd6;

    // Datapath operations selected by a control word.
    localparam logic [2:0] UOP_IDLE      = 3'd0;
    localparam logic [2:0] UOP_BEGIN     = 3'd1;
    localparam logic [2:0] UOP_TILE      = 3'd2;
    localparam logic [2:0] UOP_HIT_RD    = 3'd3;
    localparam logic [2:0] UOP_HIT_WR    = 3'd4;
    localparam logic [2:0] UOP_MISS_RD   = 3'd5;
    localparam logic [2:0] UOP_MISS_EVAL = 3'd6;

    // Sequencing modes.
    localparam logic [1:0] BR_DISP    = 2'd0; // dispatch on an accepted beat
    localparam logic [1:0] BR_DONE    = 2'd1; // back to idle
    localparam logic [1:0] BR_NEXT_IF = 2'd2; // next step if the condition holds
    localparam logic [1:0] BR_LOOP    = 2'd3; // jump to target if the condition holds

    typedef struct packed {
        logic [2:0]       op;
        logic             out_wait;
        logic [1:0]       br;
        logic [UPC_W-1:0] target;
    } ucw_t;

    typedef struct packed {
        logic              resp_kind;
        logic [SUM_W-1:0]  hit_offset;
        logic [SUM_W-1:0]  miss_offset;
        logic              totals_valid;
        logic [SUM_W-1:0]  hit_total;
        logic [SUM_W-1:0]  miss_total;
        logic              slot_assigned;
        logic [SLOT_W-1:0] assigned_slot;
        logic [DST_W-1:0]  hot_dst_index;
    } resp_t;

    // The microprogram ROM.
    function automatic ucw_t ucode_rom(input logic [UPC_W-1:0] upc);
        ucw_t w;
        case (upc)
            ST_IDLE:      w = '{op: UOP_IDLE,      out_wait: 1'b0, br: BR_DISP,    target: ST_IDLE};
            ST_BEGIN:     w = '{op: UOP_BEGIN,     out_wait: 1'b0, br: BR_DONE,    target: ST_IDLE};
            ST_TILE:      w = '{op: UOP_TILE,      out_wait: 1'b1, br: BR_DONE,    target: ST_IDLE};
            ST_HIT_RD:    w = '{op: UOP_HIT_RD,    out_wait: 1'b0, br: BR_NEXT_IF, target: ST_IDLE};
            ST_HIT_WR:    w = '{op: UOP_HIT_WR,    out_wait: 1'b0, br: BR_DONE,    target: ST_IDLE};
            ST_MISS_RD:   w = '{op: UOP_MISS_RD,   out_wait: 1'b1, br: BR_NEXT_IF, target: ST_IDLE};
            ST_MISS_EVAL: w = '{op: UOP_MISS_EVAL, out_wait: 1'b1, br: BR_LOOP,    target: ST_MISS_RD};
            default:      w = '{op: UOP_IDLE,      out_wait: 1'b0, br: BR_DONE,    target: ST_IDLE};
        endcase
        return w;
    endfunction

    // Entry step of each request kind.
    function automatic logic [UPC_W-1:0] dispatch(input logic [REQ_W-1:0] req);
        logic [UPC_W-1:0] s;
        case (req)
            REQ_BEGIN: s = ST_BEGIN;
            REQ_TILE:  s = ST_TILE;
            REQ_HIT:   s = ST_HIT_RD;
            REQ_MISS:  s = ST_MISS_RD;
            default:   s = ST_IDLE;
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/kv_miss_slot_allocator.sv
// KV miss slot allocator. Each request starts with a begin beat that clears the
// occupancy bitmap, the hit and miss running sums, the tile counter and the free
// pointer, and sets the cache base to cache_row times the active slot count
// (active_slots limited to MAX_SLOTS, APB register at byte address 0). Tile beats
// return the exclusive prefix offsets of the hit and miss counts (saturating at
// 131071), with tlast and the totals on tile number TILE_COUNT; later tiles give
// no result. Hit beats mark their slot busy when valid and in range, and give no
// result. Miss beats take the lowest free slot at or above a forward-only pointer
// and return it with cache base plus slot; an invalid miss or one that finds no
// free slot returns slot_assigned low. The block takes one beat at a time: a
// begin or tile beat passes through its own step, a hit through a read step
// and, when it is valid and in range, a write step, and a miss through a read
// step and an evaluate step, unless it fails at once in the read step, being
// invalid or finding the pointer already at the slot count. Each further
// 32-slot bitmap word the scan has to step over sends it through the read and
// evaluate steps once more, as the bitmap memory has a registered read port.
// A finished result waits in the output register and does not block the next
// input beat; the tile and miss steps wait while that register still holds a
// result that is not being taken.
// Depends on kvmsa_pkg.
`default_nettype none

module kv_miss_slot_allocator
    import kvmsa_pkg::*;
#(
    parameter int MAX_SLOTS  = MAX_SLOTS_DEF,
    parameter int TILE_COUNT = TILE_COUNT_DEF
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    // Input beats.
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    // cache_row[30:0], tile_hit_count[42:31], tile_miss_count[54:43],
    // entry_valid[55], selected_slot[87:56]
    input  wire logic [S_DATA_W-1:0] s_tdata,
    // req_type[1:0]
    input  wire logic [REQ_W-1:0]    s_tuser,
    // Result beats.
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    // hit_offset[16:0], miss_offset[33:17], hit_total[50:34], miss_total[67:51],
    // slot_assigned[68], assigned_slot[79:69], hot_dst_index[121:80], zeros above
    output logic [M_DATA_W-1:0]      m_tdata,
    // resp_kind[0]
    output logic                     m_tuser,
    // totals_valid
    output logic                     m_tlast,
    // Configuration port.
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [2:0]          paddr,
    input  wire logic [31:0]         pwdata,
    output logic [31:0]              prdata,
    output logic                     pready
);

    localparam int WORDS = (MAX_SLOTS + 31) / 32;
    localparam int WIW   = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int PW    = $clog2(WORDS * 32 + 1);
    localparam int TCW   = $clog2(TILE_COUNT + 1);
    localparam int MW    = ROW_W + PW;

    // Sequencer and configuration state.
    logic [UPC_W-1:0]  upc_reg, upc_next;
    logic [CFG_W-1:0]  active_slots_reg, active_slots_next;

    // Fields of the beat being worked on.
    logic [ROW_W-1:0]  row_reg;
    logic [CNT_W-1:0]  hcnt_reg, mcnt_reg;
    logic              ev_reg;
    logic [SEL_W-1:0]  sel_reg;

    // Request state.
    logic [WORDS-1:0]  wv_reg, wv_next;
    logic [PW-1:0]     ptr_reg, ptr_next;
    logic [DST_W-1:0]  base_reg, base_next;
    logic [SUM_W-1:0]  hsum_reg, hsum_next;
    logic [SUM_W-1:0]  msum_reg, msum_next;
    logic [TCW-1:0]    tcnt_reg, tcnt_next;

    // Bitmap memory with a registered read.
    logic [31:0]       bitmap_mem [WORDS];
    logic [31:0]       rd_word_reg;
    logic              rd_wv_reg;
    logic              mem_re, mem_we;
    logic [WIW-1:0]    mem_raddr, mem_waddr;
    logic [31:0]       mem_wdata;

    // Output register.
    logic              out_valid_reg, out_valid_next;
    resp_t             out_reg, out_next;

    ucw_t              cw;
    logic              accept, emit_ok, stall, cond;
    logic [PW-1:0]     eff_limit;
    logic [MW-1:0]     base_prod;
    logic              hit_ok;
    logic [WIW-1:0]    hit_word, ptr_word;
    logic [31:0]       cur_word, low_mask, masked;
    logic              zfound;
    logic [4:0]        zidx;
    logic [PW-1:0]     cand;
    logic [SUM_W:0]    hsum_wide, msum_wide;
    logic              cfg_wr;

    assign cw       = ucode_rom(upc_reg);
    assign s_tready = (upc_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign emit_ok  = !out_valid_reg || m_tready;
    assign stall    = cw.out_wait && !emit_ok;

    // Slot count in force, read as each beat is worked on.
    assign eff_limit = (32'(active_slots_reg) > 32'(MAX_SLOTS)) ?
                       PW'(MAX_SLOTS) : PW'(active_slots_reg);

    assign base_prod = MW'(row_reg) * MW'(eff_limit);

    assign hit_ok   = ev_reg && !sel_reg[SEL_W-1] && (sel_reg < 32'(eff_limit));
    assign hit_word = sel_reg[5 +: WIW];
    assign ptr_word = ptr_reg[5 +: WIW];

    // A word that was not written since the last begin reads as all free.
    assign cur_word = rd_wv_reg ? rd_word_reg : 32'd0;
    assign low_mask = (32'd1 << ptr_reg[4:0]) - 32'd1;
    assign masked   = cur_word | low_mask;

    // Lowest free slot of the word at or above the pointer.
    always_comb begin
        zfound = 1'b0;
        zidx   = 5'd0;
        for (int i = 31; i >= 0; i--) begin
            if (!masked[i]) begin
                zfound = 1'b1;
                zidx   = 5'(i);
            end
        end
    end

    assign cand = {ptr_reg[PW-1:5], zidx};

    assign hsum_wide = {1'b0, hsum_reg} + (SUM_W + 1)'(hcnt_reg);
    assign msum_wide = {1'b0, msum_reg} + (SUM_W + 1)'(mcnt_reg);

    // Datapath driven by the current control word.
    always_comb begin
        wv_next        = wv_reg;
        ptr_next       = ptr_reg;
        base_next      = base_reg;
        hsum_next      = hsum_reg;
        msum_next      = msum_reg;
        tcnt_next      = tcnt_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !m_tready;
        mem_re         = 1'b0;
        mem_raddr      = ptr_word;
        mem_we         = 1'b0;
        mem_waddr      = hit_word;
        mem_wdata      = cur_word | (32'd1 << sel_reg[4:0]);
        cond           = 1'b0;

        if (!stall) begin
            case (cw.op)
                UOP_BEGIN: begin
                    wv_next   = '0;
                    ptr_next  = '0;
                    hsum_next = '0;
                    msum_next = '0;
                    tcnt_next = '0;
                    base_next = DST_W'(base_prod);
                end
                UOP_TILE: begin
                    if (tcnt_reg < TCW'(TILE_COUNT)) begin
                        hsum_next = (hsum_wide > (SUM_W + 1)'(SUM_MAX)) ?
                                    SUM_MAX : hsum_wide[SUM_W-1:0];
                        msum_next = (msum_wide > (SUM_W + 1)'(SUM_MAX)) ?
                                    SUM_MAX : msum_wide[SUM_W-1:0];
                        tcnt_next = tcnt_reg + TCW'(1);
                        out_next  = '0;
                        out_next.resp_kind   = RESP_TILE;
                        out_next.hit_offset  = hsum_reg;
                        out_next.miss_offset = msum_reg;
                        if (tcnt_next == TCW'(TILE_COUNT)) begin
                            out_next.totals_valid = 1'b1;
                            out_next.hit_total    = hsum_next;
                            out_next.miss_total   = msum_next;
                        end
                        out_valid_next = 1'b1;
                    end
                end
                UOP_HIT_RD: begin
                    cond      = hit_ok;
                    mem_re    = hit_ok;
                    mem_raddr = hit_word;
                end
                UOP_HIT_WR: begin
                    mem_we            = 1'b1;
                    wv_next[hit_word] = 1'b1;
                end
                UOP_MISS_RD: begin
                    if (!ev_reg) begin
                        out_next           = '0;
                        out_next.resp_kind = RESP_MISS;
                        out_valid_next     = 1'b1;
                    end else if (ptr_reg >= eff_limit) begin
                        // Nothing free below the slot count: park the pointer there.
                        ptr_next           = eff_limit;
                        out_next           = '0;
                        out_next.resp_kind = RESP_MISS;
                        out_valid_next     = 1'b1;
                    end else begin
                        cond   = 1'b1;
                        mem_re = 1'b1;
                    end
                end
                UOP_MISS_EVAL: begin
                    if (!zfound) begin
                        // Word full from the pointer up: step to the next word.
                        ptr_next = {ptr_reg[PW-1:5] + (PW - 5)'(1), 5'd0};
                        cond     = 1'b1;
                    end else if (cand < eff_limit) begin
                        ptr_next               = cand + PW'(1);
                        out_next               = '0;
                        out_next.resp_kind     = RESP_MISS;
                        out_next.slot_assigned = 1'b1;
                        out_next.assigned_slot = SLOT_W'(cand);
                        out_next.hot_dst_index = base_reg + DST_W'(cand);
                        out_valid_next         = 1'b1;
                    end else begin
                        ptr_next           = eff_limit;
                        out_next           = '0;
                        out_next.resp_kind = RESP_MISS;
                        out_valid_next     = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Step counter with conditional jumps.
    always_comb begin
        upc_next = upc_reg;
        if (!stall) begin
            case (cw.br)
                BR_DISP:    upc_next = accept ? dispatch(s_tuser) : ST_IDLE;
                BR_DONE:    upc_next = ST_IDLE;
                BR_NEXT_IF: upc_next = cond ? upc_reg + UPC_W'(1) : ST_IDLE;
                BR_LOOP:    upc_next = cond ? cw.target : ST_IDLE;
                default:    upc_next = ST_IDLE;
            endcase
        end
    end

    // Configuration port: writes complete in the access cycle, no wait states.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign active_slots_next = (cfg_wr && (paddr[2] == REG_ACTIVE_SLOTS)) ?
                               pwdata[CFG_W-1:0] : active_slots_reg;
    assign prdata = (paddr[2] == REG_ACTIVE_SLOTS) ? 32'(active_slots_reg) : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            upc_reg          <= ST_IDLE;
            active_slots_reg <= ACTIVE_SLOTS_RST;
            wv_reg           <= '0;
            ptr_reg          <= '0;
            base_reg         <= '0;
            hsum_reg         <= '0;
            msum_reg         <= '0;
            tcnt_reg         <= '0;
            out_valid_reg    <= 1'b0;
        end else begin
            upc_reg          <= upc_next;
            active_slots_reg <= active_slots_next;
            wv_reg           <= wv_next;
            ptr_reg          <= ptr_next;
            base_reg         <= base_next;
            hsum_reg         <= hsum_next;
            msum_reg         <= msum_next;
            tcnt_reg         <= tcnt_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        out_reg <= out_next;
        if (accept) begin
            row_reg  <= s_tdata[30:0];
            hcnt_reg <= s_tdata[42:31];
            mcnt_reg <= s_tdata[54:43];
            ev_reg   <= s_tdata[55];
            sel_reg  <= s_tdata[87:56];
        end
    end

    // Bitmap memory: one write port, one registered read port.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            bitmap_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rd_word_reg <= bitmap_mem[mem_raddr];
            rd_wv_reg   <= wv_reg[mem_raddr];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.resp_kind;
    assign m_tlast  = out_reg.totals_valid;
    assign m_tdata  = {M_PAD_W'(0), out_reg.hot_dst_index, out_reg.assigned_slot,
                       out_reg.slot_assigned, out_reg.miss_total, out_reg.hit_total,
                       out_reg.miss_offset, out_reg.hit_offset};

endmodule

`default_nettype wire
